>>> src/hwr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hwr_pkg;

  localparam int unsigned GXX_W   = 20;
  localparam int unsigned GXY_W   = 21;
  localparam int unsigned SXX_W   = 27;
  localparam int unsigned SXY_W   = 28;
  localparam int unsigned COORD_W = 11;
  localparam int unsigned RESP_W  = 54;
  localparam int unsigned K_W     = 14;

  typedef struct packed {
    logic [11:0]    image_width;
    logic [11:0]    image_height;
    logic [3:0]     window_size;
    logic [K_W-1:0] k_coeff;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic clr;   // one step of the column-sum clearing pass
    logic load;  // capture the incoming word
    logic rd;    // issue memory reads
    logic col;   // column sum update and writes
    logic win;   // window sum update
    logic mul;   // products
    logic kmul;  // det and k partial products
    logic ksum;  // k term
    logic fin;   // response to output, raster advance
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic frame_start;
    logic frame_wrap;
  } status_t;

endpackage
`default_nettype wire

>>> src/hwr_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module hwr_cfg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output hwr_pkg::cfg_t    cfg_o
);

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WIN    = 2'd2;
  localparam logic [1:0] REG_K      = 2'd3;

  hwr_pkg::cfg_t cfg_q;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= 12'd640;
      cfg_q.image_height <= 12'd480;
      cfg_q.window_size  <= 4'd3;
      cfg_q.k_coeff      <= 14'd2621;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_WIDTH:  cfg_q.image_width  <= pwdata[11:0];
        REG_HEIGHT: cfg_q.image_height <= pwdata[11:0];
        REG_WIN:    cfg_q.window_size  <= pwdata[3:0];
        REG_K:      cfg_q.k_coeff      <= pwdata[13:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = {20'd0, cfg_q.image_width};
      REG_HEIGHT: prdata = {20'd0, cfg_q.image_height};
      REG_WIN:    prdata = {28'd0, cfg_q.window_size};
      REG_K:      prdata = {18'd0, cfg_q.k_coeff};
      default:    prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

>>> src/hwr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module hwr_ctrl (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  hwr_pkg::status_t st_i,
  output hwr_pkg::cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_COL, S_WIN, S_MUL, S_KMUL, S_KSUM, S_FIN
  } state_e;

  state_e state_q;
  logic   ret_read_q;
  logic   out_valid_q;
  logic   fin_go;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign fin_go      = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o      = '0;
    cmd_o.clr  = (state_q == S_CLEAR);
    cmd_o.load = (state_q == S_IDLE) && in_valid_i;
    cmd_o.rd   = (state_q == S_READ);
    cmd_o.col  = (state_q == S_COL);
    cmd_o.win  = (state_q == S_WIN);
    cmd_o.mul  = (state_q == S_MUL);
    cmd_o.kmul = (state_q == S_KMUL);
    cmd_o.ksum = (state_q == S_KSUM);
    cmd_o.fin  = fin_go;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ret_read_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          if (st_i.clr_last) begin
            state_q <= ret_read_q ? S_READ : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            if (st_i.frame_start) begin
              state_q    <= S_CLEAR;
              ret_read_q <= 1'b1;
            end else begin
              state_q <= S_READ;
            end
          end
        end
        S_READ: state_q <= S_COL;
        S_COL:  state_q <= S_WIN;
        S_WIN:  state_q <= S_MUL;
        S_MUL:  state_q <= S_KMUL;
        S_KMUL: state_q <= S_KSUM;
        S_KSUM: state_q <= S_FIN;
        S_FIN: begin
          if (fin_go) begin
            if (st_i.frame_wrap) begin
              state_q    <= S_CLEAR;
              ret_read_q <= 1'b0;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/hwr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module hwr_datapath #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048,
  parameter int unsigned MAX_WIN    = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  hwr_pkg::cfg_t    cfg_i,
  input  hwr_pkg::cmd_t    cmd_i,
  output hwr_pkg::status_t st_o,
  input  wire logic [19:0] grad_xx_i,
  input  wire logic [19:0] grad_yy_i,
  input  wire logic [20:0] grad_xy_i,
  input  wire logic        frame_start_i,
  output logic             resp_valid_o,
  output logic [10:0]      center_row_o,
  output logic [10:0]      center_col_o,
  output logic [53:0]      response_o
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned SW  = (MAX_WIN > 1) ? $clog2(MAX_WIN) : 1;
  localparam int unsigned DW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned WW  = $clog2(MAX_WIN + 1);
  localparam int unsigned SXW = SW + 2;
  localparam int unsigned LD  = MAX_WIN * MAX_WIDTH;
  localparam int unsigned LAW = $clog2(LD);
  localparam int unsigned XW  = hwr_pkg::SXX_W;
  localparam int unsigned YW  = hwr_pkg::SXY_W;
  localparam int unsigned GW  = hwr_pkg::GXX_W;
  localparam int unsigned GYW = hwr_pkg::GXY_W;
  localparam int unsigned LW  = 2 * GW + GYW;
  localparam int unsigned CSW = 2 * XW + YW;

  // ---- effective (clamped) configuration
  logic [DW-1:0] width_eff;
  logic [HW-1:0] height_eff;
  logic [WW-1:0] w_eff;

  always_comb begin
    if (cfg_i.image_width == '0) begin
      width_eff = DW'(1);
    end else if (32'(cfg_i.image_width) > 32'(MAX_WIDTH)) begin
      width_eff = DW'(MAX_WIDTH);
    end else begin
      width_eff = DW'(cfg_i.image_width);
    end
    if (cfg_i.image_height == '0) begin
      height_eff = HW'(1);
    end else if (32'(cfg_i.image_height) > 32'(MAX_HEIGHT)) begin
      height_eff = HW'(MAX_HEIGHT);
    end else begin
      height_eff = HW'(cfg_i.image_height);
    end
    if (cfg_i.window_size == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_i.window_size) > 32'(MAX_WIN)) begin
      w_eff = WW'(MAX_WIN);
    end else begin
      w_eff = WW'(cfg_i.window_size);
    end
  end

  // slot that lies w steps back, modulo MAX_WIN
  function automatic logic [SW-1:0] slot_back(input logic [SW-1:0] s, input logic [WW-1:0] w);
    logic [SXW-1:0] t;
    t = SXW'(s) + SXW'(MAX_WIN) - SXW'(w);
    if (t >= SXW'(MAX_WIN)) begin
      t = t - SXW'(MAX_WIN);
    end
    return SW'(t);
  endfunction

  // ---- raster position
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic [SW-1:0] row_slot_q, col_slot_q;
  logic [CW-1:0] clr_cnt_q;

  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic          col_wrap, row_wrap;
  logic [SW-1:0] row_slot_inc, col_slot_inc;

  assign col_inc      = {1'b0, col_q} + 1'b1;
  assign row_inc      = {1'b0, row_q} + 1'b1;
  assign col_wrap     = (32'(col_inc) >= 32'(width_eff));
  assign row_wrap     = (32'(row_inc) >= 32'(height_eff));
  assign row_slot_inc = (32'(row_slot_q) == 32'(MAX_WIN - 1)) ? '0 : row_slot_q + 1'b1;
  assign col_slot_inc = (32'(col_slot_q) == 32'(MAX_WIN - 1)) ? '0 : col_slot_q + 1'b1;

  assign st_o.clr_last    = (32'(clr_cnt_q) == 32'(MAX_WIDTH - 1));
  assign st_o.frame_start = frame_start_i;
  assign st_o.frame_wrap  = col_wrap && row_wrap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      row_slot_q <= '0;
      col_slot_q <= '0;
      clr_cnt_q  <= '0;
    end else begin
      if (cmd_i.clr) begin
        clr_cnt_q <= st_o.clr_last ? '0 : clr_cnt_q + 1'b1;
      end
      if (cmd_i.load && frame_start_i) begin
        row_q      <= '0;
        col_q      <= '0;
        row_slot_q <= '0;
        col_slot_q <= '0;
      end else if (cmd_i.fin) begin
        if (col_wrap) begin
          col_q      <= '0;
          col_slot_q <= '0;
          if (row_wrap) begin
            row_q      <= '0;
            row_slot_q <= '0;
          end else begin
            row_q      <= RW'(row_inc);
            row_slot_q <= row_slot_inc;
          end
        end else begin
          col_q      <= CW'(col_inc);
          col_slot_q <= col_slot_inc;
        end
      end
    end
  end

  // ---- input word
  logic [GW-1:0]  gxx_q, gyy_q;
  logic [GYW-1:0] gxy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      gxx_q <= grad_xx_i;
      gyy_q <= grad_yy_i;
      gxy_q <= grad_xy_i;
    end
  end

  // ---- line history and column sums
  logic [LW-1:0]  lh_mem [LD];
  logic [CSW-1:0] cs_mem [MAX_WIDTH];
  logic [LW-1:0]  lh_rdata_q;
  logic [CSW-1:0] cs_rdata_q;
  logic [LAW-1:0] lh_wr_addr, lh_rd_addr;
  logic           row_sub;

  assign row_sub    = (32'(row_q) >= 32'(w_eff));
  assign lh_wr_addr = LAW'(row_slot_q) * LAW'(MAX_WIDTH) + LAW'(col_q);
  assign lh_rd_addr = LAW'(slot_back(row_slot_q, w_eff)) * LAW'(MAX_WIDTH) + LAW'(col_q);

  logic [XW-1:0] cs_xx_new, cs_yy_new;
  logic [YW-1:0] cs_xy_new;
  logic [XW-1:0] old_xx, old_yy;
  logic [YW-1:0] old_xy;

  always_comb begin
    if (row_sub) begin
      old_xx = XW'(lh_rdata_q[LW-1 -: GW]);
      old_yy = XW'(lh_rdata_q[GYW +: GW]);
      old_xy = YW'($signed(lh_rdata_q[GYW-1:0]));
    end else begin
      old_xx = '0;
      old_yy = '0;
      old_xy = '0;
    end
    cs_xx_new = cs_rdata_q[CSW-1 -: XW] - old_xx + XW'(gxx_q);
    cs_yy_new = cs_rdata_q[YW +: XW] - old_yy + XW'(gyy_q);
    cs_xy_new = cs_rdata_q[YW-1:0] - old_xy + YW'($signed(gxy_q));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      lh_rdata_q <= lh_mem[lh_rd_addr];
      cs_rdata_q <= cs_mem[col_q];
    end
    if (cmd_i.col) begin
      lh_mem[lh_wr_addr] <= {gxx_q, gyy_q, gxy_q};
    end
    if (cmd_i.clr) begin
      cs_mem[clr_cnt_q] <= '0;
    end else if (cmd_i.col) begin
      cs_mem[col_q] <= {cs_xx_new, cs_yy_new, cs_xy_new};
    end
  end

  logic [XW-1:0] csn_xx_q, csn_yy_q;
  logic [YW-1:0] csn_xy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.col) begin
      csn_xx_q <= cs_xx_new;
      csn_yy_q <= cs_yy_new;
      csn_xy_q <= cs_xy_new;
    end
  end

  // ---- window sums over the recent column sums
  logic [XW-1:0] rc_xx_q [MAX_WIN];
  logic [XW-1:0] rc_yy_q [MAX_WIN];
  logic [YW-1:0] rc_xy_q [MAX_WIN];
  logic [XW-1:0] ws_xx_q, ws_yy_q;
  logic [YW-1:0] ws_xy_q;
  logic          col_sub;
  logic [SW-1:0] hidx;
  logic [XW-1:0] sub_xx, sub_yy, base_xx, base_yy;
  logic [YW-1:0] sub_xy, base_xy;

  assign col_sub = (32'(col_q) >= 32'(w_eff));
  assign hidx    = slot_back(col_slot_q, w_eff);

  always_comb begin
    base_xx = (col_q == '0) ? '0 : ws_xx_q;
    base_yy = (col_q == '0) ? '0 : ws_yy_q;
    base_xy = (col_q == '0) ? '0 : ws_xy_q;
    sub_xx  = col_sub ? rc_xx_q[hidx] : '0;
    sub_yy  = col_sub ? rc_yy_q[hidx] : '0;
    sub_xy  = col_sub ? rc_xy_q[hidx] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_xx_q <= '0;
      ws_yy_q <= '0;
      ws_xy_q <= '0;
      for (int i = 0; i < MAX_WIN; i++) begin
        rc_xx_q[i] <= '0;
        rc_yy_q[i] <= '0;
        rc_xy_q[i] <= '0;
      end
    end else if (cmd_i.win) begin
      ws_xx_q             <= base_xx - sub_xx + csn_xx_q;
      ws_yy_q             <= base_yy - sub_yy + csn_yy_q;
      ws_xy_q             <= base_xy - sub_xy + csn_xy_q;
      rc_xx_q[col_slot_q] <= csn_xx_q;
      rc_yy_q[col_slot_q] <= csn_yy_q;
      rc_xy_q[col_slot_q] <= csn_xy_q;
    end
  end

  // window end flag and centre, taken with the window sums
  logic                       hit_q;
  logic [hwr_pkg::COORD_W-1:0] crow_q, ccol_q;
  logic [31:0]                crow_full, ccol_full;

  assign crow_full = 32'(row_q) + 32'd1 - 32'(w_eff) + 32'(w_eff >> 1);
  assign ccol_full = 32'(col_q) + 32'd1 - 32'(w_eff) + 32'(w_eff >> 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.win) begin
      hit_q  <= (32'(row_q) + 32'd1 >= 32'(w_eff)) && (32'(col_q) + 32'd1 >= 32'(w_eff));
      crow_q <= crow_full[hwr_pkg::COORD_W-1:0];
      ccol_q <= ccol_full[hwr_pkg::COORD_W-1:0];
    end
  end

  // ---- response arithmetic
  logic [2*XW-1:0]        p_xxyy_q;
  logic signed [2*YW-1:0] p_xy_q;
  logic [2*YW-1:0]        t2_q;
  logic [YW-1:0]          trace;
  logic signed [56:0]     det_q;
  logic [hwr_pkg::K_W+YW-1:0] kp_hi_q, kp_lo_q;
  logic [69:0]            ksum;
  logic [53:0]            kterm_q;
  logic signed [57:0]     resp;
  logic [53:0]            resp_sat;

  assign trace = {1'b0, ws_xx_q} + {1'b0, ws_yy_q};
  assign ksum  = {kp_hi_q, 28'd0} + 70'(kp_lo_q) + 70'h8000;
  assign resp  = $signed({det_q[56], det_q}) - $signed({4'd0, kterm_q});

  always_comb begin
    if (resp < -58'sd9007199254740992) begin
      resp_sat = 54'h20_0000_0000_0000;
    end else if (resp > 58'sd4503599627370496) begin
      resp_sat = 54'h10_0000_0000_0000;
    end else begin
      resp_sat = resp[53:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      p_xxyy_q <= ws_xx_q * ws_yy_q;
      p_xy_q   <= $signed(ws_xy_q) * $signed(ws_xy_q);
      t2_q     <= trace * trace;
    end
    if (cmd_i.kmul) begin
      det_q   <= $signed({3'd0, p_xxyy_q}) - $signed({p_xy_q[2*YW-1], p_xy_q});
      kp_hi_q <= cfg_i.k_coeff * t2_q[2*YW-1:YW];
      kp_lo_q <= cfg_i.k_coeff * t2_q[YW-1:0];
    end
    if (cmd_i.ksum) begin
      kterm_q <= ksum[69:16];
    end
    if (cmd_i.fin) begin
      resp_valid_o <= hit_q;
      center_row_o <= hit_q ? crow_q : '0;
      center_col_o <= hit_q ? ccol_q : '0;
      response_o   <= hit_q ? resp_sat : '0;
    end
  end

endmodule
`default_nettype wire

>>> src/harris_window_response.sv
`timescale 1ns / 1ps
`default_nettype none
// Harris corner response over a square window, streamed in raster order.
// The accepted word is registered, then goes through read, column, window, multiply,
// k-product, k-sum and final steps; no new pixel is taken until that sequence ends.
// A held result word stalls the final step until the output register frees up.
// Frame start and end of frame add a pass that clears all MAX_WIDTH column-sum entries.
// Reset: async, active low; registers go to 640/480/3/2621, then the column-sum
// clearing pass runs before the first word is taken (config writes accepted meanwhile).
module harris_window_response #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048,
  parameter int unsigned MAX_WIN    = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // pixel words in
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [19:0] grad_xx_i,
  input  wire logic [19:0] grad_yy_i,
  input  wire logic [20:0] grad_xy_i,
  input  wire logic        frame_start_i,
  // result words out
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             resp_valid_o,
  output logic [10:0]      center_row_o,
  output logic [10:0]      center_col_o,
  output logic [53:0]      response_o
);

  hwr_pkg::cfg_t    cfg;
  hwr_pkg::cmd_t    cmd;
  hwr_pkg::status_t st;

  // register file; plain storage, clamping happens in the datapath
  hwr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: clear pass, read, column update, window update,
  // products, k term, then the output register handoff
  hwr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // line history, column sums, window sums and response math
  hwr_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WIN    (MAX_WIN)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .st_o          (st),
    .grad_xx_i     (grad_xx_i),
    .grad_yy_i     (grad_yy_i),
    .grad_xy_i     (grad_xy_i),
    .frame_start_i (frame_start_i),
    .resp_valid_o  (resp_valid_o),
    .center_row_o  (center_row_o),
    .center_col_o  (center_col_o),
    .response_o    (response_o)
  );

endmodule
`default_nettype wire

>>> tb/hwr_tb_pkg.sv
`timescale 1ns / 1ps
package hwr_tb_pkg;

  // register byte addresses on the config port
  localparam logic [3:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [3:0] REG_IMAGE_HEIGHT = 4'd4;
  localparam logic [3:0] REG_WINDOW_SIZE  = 4'd8;
  localparam logic [3:0] REG_K_COEFF      = 4'd12;

  typedef struct {
    logic        resp_valid;
    logic [10:0] center_row;
    logic [10:0] center_col;
    logic [53:0] response;
  } harris_result_t;

endpackage

>>> tb/harris_checker.sv
`timescale 1ns / 1ps
module harris_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic [19:0] grad_xx_i,
  input  logic [19:0] grad_yy_i,
  input  logic [20:0] grad_xy_i,
  input  logic        frame_start_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic        resp_valid_o,
  input  logic [10:0] center_row_o,
  input  logic [10:0] center_col_o,
  input  logic [53:0] response_o,
  output int          pending_o,
  output int          fail_count_o,
  output int          checked_o
);

  localparam int MW = 2048;
  localparam int MH = 2048;
  localparam int MWIN = 8;

  logic [11:0] cfg_width, cfg_height;
  logic [3:0]  cfg_win;
  logic [13:0] cfg_k;

  logic [26:0] lh_xx [MWIN*MW];
  logic [26:0] lh_yy [MWIN*MW];
  logic [27:0] lh_xy [MWIN*MW];
  logic [26:0] col_xx [MW];
  logic [26:0] col_yy [MW];
  logic [27:0] col_xy [MW];
  logic [26:0] rec_xx [MWIN];
  logic [26:0] rec_yy [MWIN];
  logic [27:0] rec_xy [MWIN];
  logic [26:0] win_xx, win_yy;
  logic [27:0] win_xy;
  int          cur_row, cur_col;

  hwr_tb_pkg::harris_result_t expected_q[$];

  assign pending_o = expected_q.size();

  task clear_columns();
    for (int i = 0; i < MW; i++) begin
      col_xx[i] = '0; col_yy[i] = '0; col_xy[i] = '0;
    end
  endtask

  task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    fail_count_o++;
  endtask

  // one pixel through the window sums, result pushed to expected_q
  task predict_pixel(input logic [19:0] gxx, input logic [19:0] gyy,
                     input logic [20:0] gxy_raw, input logic fs);
    int w, wd, ht, r, c, oi, hi_idx, slot;
    logic [27:0] gxy;
    logic [63:0] a11, a22, t, t2, kk, kterm;
    logic signed [63:0] a12, det, resp;
    hwr_tb_pkg::harris_result_t res;
    w  = (cfg_win == 0) ? 1 : (cfg_win > MWIN ? MWIN : cfg_win);
    wd = (cfg_width == 0) ? 1 : (cfg_width > MW ? MW : cfg_width);
    ht = (cfg_height == 0) ? 1 : (cfg_height > MH ? MH : cfg_height);
    gxy = {{7{gxy_raw[20]}}, gxy_raw};
    if (fs) begin
      cur_row = 0; cur_col = 0;
      clear_columns();
    end
    r = cur_row % MH;
    c = cur_col % MW;
    if (r >= w) begin
      oi = ((r - w) % MWIN) * MW + c;
      col_xx[c] -= lh_xx[oi]; col_yy[c] -= lh_yy[oi]; col_xy[c] -= lh_xy[oi];
    end
    col_xx[c] += 27'(gxx); col_yy[c] += 27'(gyy); col_xy[c] += gxy;
    oi = (r % MWIN) * MW + c;
    lh_xx[oi] = 27'(gxx); lh_yy[oi] = 27'(gyy); lh_xy[oi] = gxy;
    if (c == 0) begin
      win_xx = '0; win_yy = '0; win_xy = '0;
    end
    if (c >= w) begin
      hi_idx = (c - w) % MWIN;
      win_xx -= rec_xx[hi_idx]; win_yy -= rec_yy[hi_idx]; win_xy -= rec_xy[hi_idx];
    end
    slot = c % MWIN;
    rec_xx[slot] = col_xx[c]; rec_yy[slot] = col_yy[c]; rec_xy[slot] = col_xy[c];
    win_xx += col_xx[c]; win_yy += col_yy[c]; win_xy += col_xy[c];

    res = '{1'b0, 11'd0, 11'd0, 54'd0};
    if (r + 1 >= w && c + 1 >= w) begin
      a11 = 64'(win_xx);
      a22 = 64'(win_yy);
      a12 = 64'($signed(win_xy));
      det = $signed(a11 * a22) - a12 * a12;
      t = a11 + a22;
      t2 = t * t;
      kk = 64'(cfg_k);
      // k * t^2 / 2^16 rounded half up, split to stay in 64 bits
      kterm = kk * (t2 >> 16) + ((kk * (t2 & 64'hFFFF) + 64'h8000) >> 16);
      resp = det - $signed(kterm);
      if (resp < -(64'sd1 <<< 53)) resp = -(64'sd1 <<< 53);
      if (resp > (64'sd1 <<< 52)) resp = 64'sd1 <<< 52;
      res.resp_valid = 1'b1;
      res.center_row = 11'(r - (w - 1) + w / 2);
      res.center_col = 11'(c - (w - 1) + w / 2);
      res.response   = resp[53:0];
    end
    expected_q.push_back(res);

    cur_col = c + 1;
    if (cur_col >= wd) begin
      cur_col = 0;
      cur_row = r + 1;
      if (cur_row >= ht) begin
        cur_row = 0;
        clear_columns();
      end
    end else begin
      cur_row = r;
    end
  endtask

  task compare_result();
    hwr_tb_pkg::harris_result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("unexpected result word", 64'd1, 64'd0);
    end else begin
      want = expected_q.pop_front();
      checked_o++;
      if (resp_valid_o !== want.resp_valid)
        report_mismatch("resp_valid", 64'(resp_valid_o), 64'(want.resp_valid));
      if (center_row_o !== want.center_row)
        report_mismatch("center_row", 64'(center_row_o), 64'(want.center_row));
      if (center_col_o !== want.center_col)
        report_mismatch("center_col", 64'(center_col_o), 64'(want.center_col));
      if (response_o !== want.response)
        report_mismatch("response", 64'(response_o), 64'(want.response));
    end
  endtask

  initial begin
    fail_count_o = 0;
    checked_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width = 12'd640; cfg_height = 12'd480; cfg_win = 4'd3; cfg_k = 14'd2621;
      clear_columns();
      for (int i = 0; i < MWIN; i++) begin
        rec_xx[i] = '0; rec_yy[i] = '0; rec_xy[i] = '0;
      end
      win_xx = '0; win_yy = '0; win_xy = '0;
      cur_row = 0; cur_col = 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          hwr_tb_pkg::REG_IMAGE_WIDTH:  cfg_width  = pwdata[11:0];
          hwr_tb_pkg::REG_IMAGE_HEIGHT: cfg_height = pwdata[11:0];
          hwr_tb_pkg::REG_WINDOW_SIZE:  cfg_win    = pwdata[3:0];
          hwr_tb_pkg::REG_K_COEFF:      cfg_k      = pwdata[13:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o)
        predict_pixel(grad_xx_i, grad_yy_i, grad_xy_i, frame_start_i);
      if (out_valid_o && out_ready_i)
        compare_result();
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int IDLE_PCT    = 18;
  localparam int HOLD_CYCLES = 400;
  // cycles without any accepted word before giving up; covers the
  // clearing pass plus the long receiver hold-off with margin
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        in_valid_i, in_ready_o;
  logic [19:0] grad_xx_i, grad_yy_i;
  logic [20:0] grad_xy_i;
  logic        frame_start_i;
  logic        out_valid_o, out_ready_i;
  logic        resp_valid_o;
  logic [10:0] center_row_o, center_col_o;
  logic [53:0] response_o;

  int pending, fail_count, checked;
  int words_sent, phases_run, random_sent;
  bit calm;      // no random idling on either side while set
  bit hold_req;  // asks the receiver for one long hold-off
  int quiet_cycles;

  harris_window_response dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .grad_xx_i, .grad_yy_i, .grad_xy_i, .frame_start_i,
    .out_valid_o, .out_ready_i, .resp_valid_o, .center_row_o, .center_col_o, .response_o
  );

  harris_checker u_checker (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_ready_o, .grad_xx_i, .grad_yy_i, .grad_xy_i, .frame_start_i,
    .out_valid_o, .out_ready_i, .resp_valid_o, .center_row_o, .center_col_o, .response_o,
    .pending_o(pending), .fail_count_o(fail_count), .checked_o(checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // --- watchdog: any accepted word on either channel resets the count ---
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --- result side: random back-pressure plus one long hold-off on request ---
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // APB write: setup cycle, then access cycle; pready is always high
  task cfg_write(input logic [3:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // offer one pixel word, with random idle cycles ahead of it
  task send_pixel(input logic [19:0] xx, input logic [19:0] yy,
                  input logic [20:0] xy, input logic fs);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    grad_xx_i <= xx; grad_yy_i <= yy; grad_xy_i <= xy; frame_start_i <= fs;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  // random content, weighted toward the corners of each field
  task send_random_pixel(input logic fs);
    int kind;
    kind = $urandom_range(9);
    case (kind)
      0: send_pixel(20'hFFFFF, 20'hFFFFF, $urandom_range(1) ? 21'h0FFFFF : 21'h100000, fs);
      1: send_pixel(20'h0, 20'h0, 21'h0, fs);
      2: send_pixel(20'($urandom_range(15)), 20'($urandom_range(15)),
                    21'($urandom_range(31)) - 21'd16, fs);
      default: send_pixel(20'($urandom), 20'($urandom), 21'($urandom), fs);
    endcase
  endtask

  // wait until every expected result is back, then for the pipeline tail
  task settle();
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // mode 0: random pixels; mode 1: full-scale xx/yy, xy at the negative end;
  // mode 2: full-scale xx/yy with xy zero (largest determinant)
  task run_phase(input int wd, input int ht, input int win, input int k,
                 input int n_words, input int mode);
    bit fs;
    cfg_write(hwr_tb_pkg::REG_IMAGE_WIDTH, 32'(wd));
    cfg_write(hwr_tb_pkg::REG_IMAGE_HEIGHT, 32'(ht));
    cfg_write(hwr_tb_pkg::REG_WINDOW_SIZE, 32'(win));
    cfg_write(hwr_tb_pkg::REG_K_COEFF, 32'(k));
    for (int i = 0; i < n_words; i++) begin
      // every phase restarts the raster; stray frame starts now and then
      fs = (i == 0) || ($urandom_range(199) == 0);
      case (mode)
        1: send_pixel(20'hFFFFF, 20'hFFFFF, 21'h100000, fs);
        2: send_pixel(20'hFFFFF, 20'hFFFFF, 21'h0, fs);
        default: send_random_pixel(fs);
      endcase
    end
    settle();
    phases_run++;
  endtask

  initial begin
    int wd, ht, win, n;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid_i = 1'b0; grad_xx_i = '0; grad_yy_i = '0; grad_xy_i = '0;
    frame_start_i = 1'b0;
    calm = 1'b0; hold_req = 1'b0; quiet_cycles = 0;
    words_sent = 0; phases_run = 0; random_sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words under the reset configuration (640x480, 3x3)
    send_pixel(20'h0,     20'h0,     21'h0,      1'b1);
    send_pixel(20'hFFFFF, 20'hFFFFF, 21'h0FFFFF, 1'b0);
    send_pixel(20'hFFFFF, 20'h0,     21'h100000, 1'b0);
    send_pixel(20'h0,     20'hFFFFF, 21'h1FFFFF, 1'b0);
    send_pixel(20'hAAAAA, 20'h55555, 21'h0AAAAA, 1'b0);
    send_pixel(20'h55555, 20'hAAAAA, 21'h155555, 1'b0);
    send_pixel(20'h00001, 20'h80000, 21'h000001, 1'b0);
    send_pixel(20'h80000, 20'h00001, 21'h100001, 1'b0);
    // frame start in the middle of a row
    send_pixel(20'h12345, 20'h6789A, 21'h0BCDEF, 1'b1);
    send_pixel(20'hFFFFF, 20'hFFFFF, 21'h100000, 1'b0);
    settle();

    // full-scale data in an 8x8 window, k at both ends;
    // the receiver holds off early in the first phase so the input backs up
    hold_req = 1'b1;
    run_phase(8, 8, 8, 16383, 64, 1);
    run_phase(8, 8, 8, 0, 64, 2);
    run_phase(9, 9, 8, 16383, 81, 2);
    // one-pixel frames and out-of-range register values (clamped)
    run_phase(1, 1, 1, 1, 6, 0);
    run_phase(0, 0, 0, 2621, 6, 0);
    run_phase(3, 2, 15, 100, 12, 0);
    // oversized row and column settings, run back to back without idling
    calm = 1'b1;
    run_phase(4095, 1, 0, 8191, 60, 0);
    run_phase(1, 4095, 1, 4096, 60, 0);
    run_phase(2048, 2, 2, 2621, 60, 0);
    calm = 1'b0;

    // random geometries, mostly well-formed frames
    while (random_sent < 180) begin
      wd  = $urandom_range(1, 12);
      ht  = $urandom_range(1, 10);
      win = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 8);
      n   = wd * ht * $urandom_range(1, 2) + $urandom_range(3);
      if (n > 150) n = 150;
      if (phases_run % 5 == 2) hold_req = 1'b1;  // receiver stalls, input backs up
      calm = (phases_run % 7 == 3);
      run_phase(wd, ht, win, $urandom_range(16383), n, 0);
      random_sent += n;
    end
    calm = 1'b0;

    $display("covered %0d pixel words in %0d configurations, %0d results compared",
             words_sent, phases_run, checked);
    $display("frames 1x1 to 12x10, oversized sizes clamped, windows 0 to 15, k 0 to 16383");
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/hwr_pkg.sv
src/hwr_cfg.sv
src/hwr_ctrl.sv
src/hwr_datapath.sv
src/harris_window_response.sv
tb/hwr_tb_pkg.sv
tb/harris_checker.sv
tb/tb_top.sv
